// ===== sv/free_list_allocator_top_assert.svh =====
// Assertion macros for the free list allocator checker.
// Depends on nothing; included by the checker file.
`ifndef FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH
`define FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication
`define FLA_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FLA_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/fla_pkg.sv =====
// Shared types and constants of the free list allocator.
// Depends on nothing; imported by every module of the block but fla_ram.
`timescale 1ns / 1ps
package fla_pkg;

    localparam int ADDR_W = 20;
    localparam int LEN_W  = 21;
    localparam int SIZE_W = 22;
    localparam int NEED_W = 23;
    localparam int PAGES_W = 9;

    localparam int DEF_FREE_ENTRIES = 16;
    localparam int DEF_LIVE_ENTRIES = 16;
    localparam int DEF_PAGE_BYTES   = 4096;
    localparam int DEF_HEADER_BYTES = 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int MAX_PAGES   = 256;
    localparam int MAX_REGION  = 1048576;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_BAD_PTR  = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [1:0] FIT_BEST  = 2'd0;
    localparam logic [1:0] FIT_WORST = 2'd1;
    localparam logic [1:0] FIT_FIRST = 2'd2;

    typedef struct packed {
        logic              mode;
        logic [1:0]        fit;
        logic [SIZE_W-1:0] size;
        logic [NEED_W-1:0] need;
        logic [ADDR_W-1:0] addr;
    } cmd_t;

endpackage

// ===== sv/fla_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
module fla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/fla_front.sv =====
// Front end: takes requests, rounds sizes and builds queue commands.
// Depends on fla_pkg.
`timescale 1ns / 1ps
module fla_front
    import fla_pkg::*;
#(
    parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
    input  logic              start,
    output logic              busy,
    input  logic              mode,
    input  logic [20:0]       request_bytes,
    input  logic [1:0]        fit_policy,
    input  logic [19:0]       release_address,
    input  logic              q_full,
    output logic              push,
    output cmd_t              push_cmd
);

    logic [SIZE_W-1:0] sum;
    logic [SIZE_W-1:0] size;

    always_comb
    begin
        sum  = {1'b0, request_bytes} + SIZE_W'(7);
        size = sum & ~SIZE_W'(7);
        if (size == '0)
        begin
            size = SIZE_W'(8);
        end
        push_cmd.mode = mode;
        push_cmd.fit  = fit_policy;
        push_cmd.size = size;
        push_cmd.need = {1'b0, size} + NEED_W'(HEADER_BYTES);
        push_cmd.addr = release_address;
    end

    assign busy = q_full;
    assign push = start && !q_full;

endmodule

// ===== sv/fla_queue.sv =====
// Short command queue between front and back ends.
// Depends on fla_pkg.
`timescale 1ns / 1ps
module fla_queue
    import fla_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic empty
);

    localparam int QIW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    cmd_t           slot_reg [QUEUE_DEPTH];
    logic [QIW-1:0] wr_reg, wr_next;
    logic [QIW-1:0] rd_reg, rd_next;
    logic [QCW-1:0] cnt_reg, cnt_next;

    assign full    = (cnt_reg == QCW'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign pop_cmd = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == QIW'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == QIW'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_cmd;
        end
    end

endmodule

// ===== sv/fla_back.sv =====
// Back end: free extent table, live table and the sequencer that runs commands.
// Depends on fla_pkg and fla_ram.
`timescale 1ns / 1ps
module fla_back
    import fla_pkg::*;
#(
    parameter int FREE_ENTRIES = DEF_FREE_ENTRIES,
    parameter int LIVE_ENTRIES = DEF_LIVE_ENTRIES,
    parameter int PAGE_BYTES   = DEF_PAGE_BYTES,
    parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  cmd_t               q_cmd,
    output logic               pop,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [PAGES_W-1:0] region_pages,
    output logic               done,
    output logic [ADDR_W-1:0]  granted_address,
    output logic [1:0]         status
);

    localparam int FIW = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
    localparam int FCW = $clog2(FREE_ENTRIES + 1);
    localparam int LIW = (LIVE_ENTRIES > 1) ? $clog2(LIVE_ENTRIES) : 1;
    localparam int LCW = $clog2(LIVE_ENTRIES + 1);
    localparam int EW  = ADDR_W + LEN_W;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE,
        S_A_RD, S_A_EV, S_A_SLOT, S_A_COMMIT,
        S_F_RD, S_F_EV, S_M_RD, S_M_EV,
        S_C_RD, S_C_EV, S_C_LAST
    } state_t;

    function automatic logic [LEN_W-1:0] region_len(input logic [PAGES_W-1:0] v);
        logic [PAGES_W-1:0] p;
        logic [25:0]        prod;
        p = v;
        if (p == '0)
        begin
            p = PAGES_W'(1);
        end
        if (p > PAGES_W'(MAX_PAGES))
        begin
            p = PAGES_W'(MAX_PAGES);
        end
        prod = 26'(p) * 26'(PAGE_BYTES);
        if (prod > 26'(MAX_REGION))
        begin
            prod = 26'(MAX_REGION);
        end
        return prod[LEN_W-1:0];
    endfunction

    state_t             state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [PAGES_W-1:0] region_reg, region_next;
    logic [FCW-1:0]     count_reg, count_next;
    logic [FCW-1:0]     idx_reg, idx_next;
    logic [FCW-1:0]     wr_reg, wr_next;
    logic               pick_found_reg, pick_found_next;
    logic [FIW-1:0]     pick_idx_reg, pick_idx_next;
    logic [ADDR_W-1:0]  pick_start_reg, pick_start_next;
    logic [LEN_W-1:0]   pick_len_reg, pick_len_next;
    logic [LEN_W-1:0]   best_reg, best_next;
    logic [LCW-1:0]     slot_reg, slot_next;
    logic               slot_found_reg, slot_found_next;
    logic [LEN_W-1:0]   lo_reg, lo_next;
    logic [LEN_W-1:0]   hi_reg, hi_next;
    logic               changed_reg, changed_next;
    logic               merged_reg, merged_next;
    logic [ADDR_W-1:0]  pend_start_reg, pend_start_next;
    logic [LEN_W-1:0]   pend_len_reg, pend_len_next;
    logic               gone_reg [FREE_ENTRIES];
    logic               gone_next [FREE_ENTRIES];
    logic               live_valid_reg [LIVE_ENTRIES];
    logic               live_valid_next [LIVE_ENTRIES];
    logic               done_reg, done_next;
    logic [ADDR_W-1:0]  gaddr_reg, gaddr_next;
    logic [1:0]         status_reg, status_next;

    logic              ext_we;
    logic [FIW-1:0]    ext_waddr;
    logic [EW-1:0]     ext_wdata;
    logic [EW-1:0]     ext_rdata;
    logic              live_we;
    logic [EW-1:0]     live_wdata;
    logic [EW-1:0]     live_rdata;
    logic [ADDR_W-1:0] ext_rd_start;
    logic [LEN_W-1:0]  ext_rd_len;
    logic [LEN_W-1:0]  ext_rd_end;
    logic [ADDR_W-1:0] live_rd_start;
    logic [LEN_W-1:0]  live_rd_len;
    logic              fits;
    logic              take;
    logic              stop;
    logic [SIZE_W-1:0] carve;

    fla_ram #(.WIDTH(EW), .DEPTH(FREE_ENTRIES)) u_ext_ram (
        .clk   (clk),
        .we    (ext_we),
        .waddr (ext_waddr),
        .wdata (ext_wdata),
        .raddr (idx_reg[FIW-1:0]),
        .rdata (ext_rdata)
    );

    fla_ram #(.WIDTH(EW), .DEPTH(LIVE_ENTRIES)) u_live_ram (
        .clk   (clk),
        .we    (live_we),
        .waddr (slot_reg[LIW-1:0]),
        .wdata (live_wdata),
        .raddr (slot_reg[LIW-1:0]),
        .rdata (live_rdata)
    );

    assign ext_rd_start  = ext_rdata[EW-1:LEN_W];
    assign ext_rd_len    = ext_rdata[LEN_W-1:0];
    assign ext_rd_end    = {1'b0, ext_rd_start} + ext_rd_len;
    assign live_rd_start = live_rdata[EW-1:LEN_W];
    assign live_rd_len   = live_rdata[LEN_W-1:0];
    assign carve         = {2'b00, pick_start_reg} + {1'b0, pick_len_reg} - cmd_reg.size;

    assign cfg_ready       = (state_reg == S_IDLE) && q_empty;
    assign done            = done_reg;
    assign granted_address = gaddr_reg;
    assign status          = status_reg;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        region_next     = region_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        wr_next         = wr_reg;
        pick_found_next = pick_found_reg;
        pick_idx_next   = pick_idx_reg;
        pick_start_next = pick_start_reg;
        pick_len_next   = pick_len_reg;
        best_next       = best_reg;
        slot_next       = slot_reg;
        slot_found_next = slot_found_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        changed_next    = changed_reg;
        merged_next     = merged_reg;
        pend_start_next = pend_start_reg;
        pend_len_next   = pend_len_reg;
        gone_next       = gone_reg;
        live_valid_next = live_valid_reg;
        done_next       = 1'b0;
        gaddr_next      = gaddr_reg;
        status_next     = status_reg;
        pop             = 1'b0;
        ext_we          = 1'b0;
        ext_waddr       = '0;
        ext_wdata       = '0;
        live_we         = 1'b0;
        live_wdata      = '0;
        fits            = ({2'b00, ext_rd_len} >= cmd_reg.need);
        take            = 1'b0;
        stop            = 1'b0;

        // search a free live slot alongside the extent scan
        if ((state_reg == S_A_RD || state_reg == S_A_EV || state_reg == S_A_SLOT)
            && !slot_found_reg && slot_reg < LCW'(LIVE_ENTRIES))
        begin
            if (!live_valid_reg[slot_reg[LIW-1:0]])
            begin
                slot_found_next = 1'b1;
            end
            else
            begin
                slot_next = slot_reg + 1'b1;
            end
        end

        unique case (state_reg)
            S_INIT:
            begin
                ext_we     = 1'b1;
                ext_waddr  = '0;
                ext_wdata  = {ADDR_W'(0), region_len(region_reg)};
                count_next = FCW'(1);
                for (int i = 0; i < LIVE_ENTRIES; i++)
                begin
                    live_valid_next[i] = 1'b0;
                end
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (cfg_valid && cfg_ready)
                begin
                    region_next = region_pages;
                    state_next  = S_INIT;
                end
                else if (!q_empty)
                begin
                    pop             = 1'b1;
                    cmd_next        = q_cmd;
                    idx_next        = '0;
                    slot_next       = '0;
                    slot_found_next = 1'b0;
                    pick_found_next = 1'b0;
                    best_next       = (q_cmd.fit == FIT_BEST) ? '1 : '0;
                    state_next      = (q_cmd.mode == MODE_ALLOC) ? S_A_RD : S_F_RD;
                end
            end
            S_A_RD:
            begin
                state_next = (idx_reg < count_reg) ? S_A_EV : S_A_SLOT;
            end
            S_A_EV:
            begin
                unique case (cmd_reg.fit)
                    FIT_BEST:  take = fits && (ext_rd_len <= best_reg);
                    FIT_WORST: take = fits && (ext_rd_len >= best_reg);
                    FIT_FIRST:
                    begin
                        take = fits;
                        stop = fits;
                    end
                    default:   take = 1'b0;
                endcase
                if (take)
                begin
                    best_next       = ext_rd_len;
                    pick_found_next = 1'b1;
                    pick_idx_next   = idx_reg[FIW-1:0];
                    pick_start_next = ext_rd_start;
                    pick_len_next   = ext_rd_len;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = stop ? S_A_SLOT : S_A_RD;
            end
            S_A_SLOT:
            begin
                if (!pick_found_reg)
                begin
                    done_next   = 1'b1;
                    gaddr_next  = '0;
                    status_next = ST_NO_SPACE;
                    state_next  = S_IDLE;
                end
                else if (slot_found_reg)
                begin
                    state_next = S_A_COMMIT;
                end
                else if (slot_reg >= LCW'(LIVE_ENTRIES))
                begin
                    done_next   = 1'b1;
                    gaddr_next  = '0;
                    status_next = ST_FULL;
                    state_next  = S_IDLE;
                end
            end
            S_A_COMMIT:
            begin
                ext_we      = 1'b1;
                ext_waddr   = pick_idx_reg;
                ext_wdata   = {pick_start_reg, pick_len_reg - cmd_reg.need[LEN_W-1:0]};
                live_we     = 1'b1;
                live_wdata  = {carve[ADDR_W-1:0], cmd_reg.size[LEN_W-1:0]};
                live_valid_next[slot_reg[LIW-1:0]] = 1'b1;
                done_next   = 1'b1;
                gaddr_next  = carve[ADDR_W-1:0];
                status_next = ST_OK;
                state_next  = S_IDLE;
            end
            S_F_RD:
            begin
                if (slot_reg < LCW'(LIVE_ENTRIES))
                begin
                    state_next = S_F_EV;
                end
                else
                begin
                    done_next   = 1'b1;
                    gaddr_next  = '0;
                    status_next = ST_BAD_PTR;
                    state_next  = S_IDLE;
                end
            end
            S_F_EV:
            begin
                if (live_valid_reg[slot_reg[LIW-1:0]] && live_rd_start == cmd_reg.addr)
                begin
                    lo_next      = {1'b0, cmd_reg.addr} - LEN_W'(HEADER_BYTES);
                    hi_next      = {1'b0, cmd_reg.addr} + live_rd_len;
                    merged_next  = 1'b0;
                    changed_next = 1'b0;
                    idx_next     = '0;
                    for (int i = 0; i < FREE_ENTRIES; i++)
                    begin
                        gone_next[i] = 1'b0;
                    end
                    state_next = S_M_RD;
                end
                else
                begin
                    slot_next  = slot_reg + 1'b1;
                    state_next = S_F_RD;
                end
            end
            S_M_RD:
            begin
                if (idx_reg < count_reg)
                begin
                    state_next = S_M_EV;
                end
                else if (changed_reg)
                begin
                    changed_next = 1'b0;
                    idx_next     = '0;
                end
                else if (!merged_reg && count_reg >= FCW'(FREE_ENTRIES))
                begin
                    done_next   = 1'b1;
                    gaddr_next  = '0;
                    status_next = ST_FULL;
                    state_next  = S_IDLE;
                end
                else
                begin
                    idx_next        = '0;
                    wr_next         = '0;
                    pend_start_next = lo_reg[ADDR_W-1:0];
                    pend_len_next   = hi_reg - lo_reg;
                    state_next      = S_C_RD;
                end
            end
            S_M_EV:
            begin
                if (!gone_reg[idx_reg[FIW-1:0]]
                    && (ext_rd_end == lo_reg || {1'b0, ext_rd_start} == hi_reg))
                begin
                    if ({1'b0, ext_rd_start} < lo_reg)
                    begin
                        lo_next = {1'b0, ext_rd_start};
                    end
                    if (ext_rd_end > hi_reg)
                    begin
                        hi_next = ext_rd_end;
                    end
                    gone_next[idx_reg[FIW-1:0]] = 1'b1;
                    merged_next  = 1'b1;
                    changed_next = 1'b1;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = S_M_RD;
            end
            S_C_RD:
            begin
                state_next = (idx_reg < count_reg) ? S_C_EV : S_C_LAST;
            end
            S_C_EV:
            begin
                if (!gone_reg[idx_reg[FIW-1:0]])
                begin
                    ext_we          = 1'b1;
                    ext_waddr       = wr_reg[FIW-1:0];
                    ext_wdata       = {pend_start_reg, pend_len_reg};
                    pend_start_next = ext_rd_start;
                    pend_len_next   = ext_rd_len;
                    wr_next         = wr_reg + 1'b1;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = S_C_RD;
            end
            S_C_LAST:
            begin
                ext_we      = 1'b1;
                ext_waddr   = wr_reg[FIW-1:0];
                ext_wdata   = {pend_start_reg, pend_len_reg};
                count_next  = wr_reg + 1'b1;
                live_valid_next[slot_reg[LIW-1:0]] = 1'b0;
                done_next   = 1'b1;
                gaddr_next  = '0;
                status_next = ST_OK;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            region_reg     <= PAGES_W'(1);
            count_reg      <= FCW'(1);
            idx_reg        <= '0;
            wr_reg         <= '0;
            pick_found_reg <= 1'b0;
            slot_reg       <= '0;
            slot_found_reg <= 1'b0;
            changed_reg    <= 1'b0;
            merged_reg     <= 1'b0;
            done_reg       <= 1'b0;
            status_reg     <= ST_OK;
            gaddr_reg      <= '0;
            for (int i = 0; i < FREE_ENTRIES; i++)
            begin
                gone_reg[i] <= 1'b0;
            end
            for (int i = 0; i < LIVE_ENTRIES; i++)
            begin
                live_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            region_reg     <= region_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            wr_reg         <= wr_next;
            pick_found_reg <= pick_found_next;
            slot_reg       <= slot_next;
            slot_found_reg <= slot_found_next;
            changed_reg    <= changed_next;
            merged_reg     <= merged_next;
            done_reg       <= done_next;
            status_reg     <= status_next;
            gaddr_reg      <= gaddr_next;
            gone_reg       <= gone_next;
            live_valid_reg <= live_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        pick_idx_reg   <= pick_idx_next;
        pick_start_reg <= pick_start_next;
        pick_len_reg   <= pick_len_next;
        best_reg       <= best_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        pend_start_reg <= pend_start_next;
        pend_len_reg   <= pend_len_next;
    end

endmodule

// ===== sv/free_list_allocator_top.sv =====
// Free list allocator over a paged byte region: allocate and free requests,
// one result per request. Holds front end, command queue and back end.
// Depends on fla_pkg, fla_front, fla_queue, fla_back.
//
// A request is taken when start is high and busy is low; busy rises only when
// the two-entry command queue is full. Each request yields one result, shown
// for a single cycle with done high; the receiver cannot stall it. Requests
// run one at a time in the back end, which reads its tables through RAMs with
// registered reads, a read and an evaluate state per visited entry. Each
// request is popped in the idle state, and its result shows on the registered
// done after the last back end step. Allocate: a read and an evaluate step for
// each free extent up to the fit (all of them for best and worst fit, plus a
// read to close a full scan), then a step to check the live slot search and a
// commit step. The slot search visits one live entry per cycle alongside the
// extent scan and holds the check until it ends. Free: a read and an evaluate
// step per live entry up to the match (all of them and a closing read when
// there is none), then the same per extent in each merge pass (one pass more
// than there are merge rounds) and in the table rebuild, which ends with a
// closing read and a write. After reset and each region_pages write the back
// end rebuilds its tables in its init state; cfg_ready is low meanwhile.
`timescale 1ns / 1ps
module free_list_allocator_top
    import fla_pkg::*;
#(
    parameter int FREE_ENTRIES = DEF_FREE_ENTRIES,
    parameter int LIVE_ENTRIES = DEF_LIVE_ENTRIES,
    parameter int PAGE_BYTES   = DEF_PAGE_BYTES,
    parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [20:0] request_bytes,
    input  logic [1:0]  fit_policy,
    input  logic [19:0] release_address,
    output logic        done,
    output logic [19:0] granted_address,
    output logic [1:0]  status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  region_pages
);

    logic push;
    cmd_t push_cmd;
    logic q_full;
    logic q_empty;
    logic pop;
    cmd_t pop_cmd;

    fla_front #(.HEADER_BYTES(HEADER_BYTES)) u_front (
        .start           (start),
        .busy            (busy),
        .mode            (mode),
        .request_bytes   (request_bytes),
        .fit_policy      (fit_policy),
        .release_address (release_address),
        .q_full          (q_full),
        .push            (push),
        .push_cmd        (push_cmd)
    );

    fla_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    fla_back #(
        .FREE_ENTRIES (FREE_ENTRIES),
        .LIVE_ENTRIES (LIVE_ENTRIES),
        .PAGE_BYTES   (PAGE_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_empty         (q_empty),
        .q_cmd           (pop_cmd),
        .pop             (pop),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .region_pages    (region_pages),
        .done            (done),
        .granted_address (granted_address),
        .status          (status)
    );

endmodule

// ===== sv/fla_checker.sv =====
// Port-level checks of the free list allocator, bound to the top level.
// Depends on fla_pkg and free_list_allocator_top_assert.svh.
`timescale 1ns / 1ps
`include "free_list_allocator_top_assert.svh"
module fla_checker
    import fla_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [19:0] granted_address,
    input logic [1:0]  status,
    input logic        cfg_valid,
    input logic        cfg_ready
);

    `FLA_ASSERT_IMPL(a_fail_zero, clk, rst_n, done && (status != ST_OK), granted_address == 20'd0, "failed request returned an address")
    `FLA_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done, "results on consecutive cycles")
    `FLA_ASSERT_NEXT(a_accept_blocks_cfg, clk, rst_n, start && !busy, !cfg_ready, "config open with request pending")
    `FLA_ASSERT_NEXT(a_cfg_rebuild, clk, rst_n, cfg_valid && cfg_ready, !cfg_ready, "no table rebuild after config write")

endmodule

bind free_list_allocator_top fla_checker u_fla_checker (.*);

// ===== dv/free_list_allocator_checker.sv =====
// Checker for the free list allocator: watches request, result and region write.
// Keeps its own free and live tables, predicts each result and compares it.
// Depends on fla_pkg.
`timescale 1ns / 1ps
module free_list_allocator_checker
    import fla_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        mode,
    input  logic [20:0] request_bytes,
    input  logic [1:0]  fit_policy,
    input  logic [19:0] release_address,
    input  logic        done,
    input  logic [19:0] granted_address,
    input  logic [1:0]  status,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [8:0]  region_pages,
    output int          fail_count,
    output int          pending,
    output int          results_seen
);

    localparam int NFREE = DEF_FREE_ENTRIES;
    localparam int NLIVE = DEF_LIVE_ENTRIES;

    typedef struct packed {
        logic [19:0] addr;
        logic [1:0]  st;
    } grant_t;

    logic [8:0]  pages_q;
    logic [19:0] ext_start [NFREE];
    logic [20:0] ext_len   [NFREE];
    logic        ext_vld   [NFREE];
    logic [19:0] live_start [NLIVE];
    logic [20:0] live_len   [NLIVE];
    logic        live_vld   [NLIVE];
    grant_t      grants_due [$];

    function automatic int unsigned region_size(logic [8:0] p);
        int unsigned n;
        n = p;
        if (n < 1) n = 1;
        if (n > MAX_PAGES) n = MAX_PAGES;
        n = n * DEF_PAGE_BYTES;
        if (n > MAX_REGION) n = MAX_REGION;
        return n;
    endfunction

    function automatic void clear_tables();
        for (int i = 0; i < NFREE; i++)
        begin
            ext_start[i] = '0;
            ext_len[i] = '0;
            ext_vld[i] = 1'b0;
        end
        for (int i = 0; i < NLIVE; i++)
        begin
            live_start[i] = '0;
            live_len[i] = '0;
            live_vld[i] = 1'b0;
        end
        ext_len[0] = region_size(pages_q);
        ext_vld[0] = 1'b1;
    endfunction

    function automatic grant_t allocate(logic [20:0] req, logic [1:0] pol);
        int unsigned size, need, best, len;
        int pick, slot;
        grant_t g;
        g = '{addr: '0, st: ST_NO_SPACE};
        size = (int'(req) + 7) & ~32'd7;
        if (size == 0) size = 8;
        need = size + DEF_HEADER_BYTES;
        best = (pol == FIT_BEST) ? 32'hFFFF_FFFF : 0;
        pick = -1;
        for (int i = 0; i < NFREE; i++)
        begin
            len = ext_len[i];
            if (!ext_vld[i] || len < need) continue;
            if (pol == FIT_BEST)
            begin
                if (len <= best) begin best = len; pick = i; end
            end
            else if (pol == FIT_WORST)
            begin
                if (len >= best) begin best = len; pick = i; end
            end
            else if (pol == FIT_FIRST)
            begin
                pick = i;
                break;
            end
        end
        if (pick < 0) return g;
        slot = 0;
        while (slot < NLIVE && live_vld[slot]) slot++;
        if (slot >= NLIVE)
        begin
            g.st = ST_FULL;
            return g;
        end
        g.addr = 20'(ext_start[pick] + ext_len[pick] - size);
        g.st = ST_OK;
        ext_len[pick] = 21'(ext_len[pick] - need);
        live_vld[slot] = 1'b1;
        live_start[slot] = g.addr;
        live_len[slot] = 21'(size);
        return g;
    endfunction

    function automatic grant_t release_block(logic [19:0] a);
        int slot, used, n;
        int unsigned lo, hi, s, e;
        logic gone [NFREE];
        logic [19:0] ns [NFREE];
        logic [20:0] nl [NFREE];
        logic merged, changed;
        grant_t g;
        g = '{addr: '0, st: ST_BAD_PTR};
        slot = 0;
        while (slot < NLIVE && !(live_vld[slot] && live_start[slot] == a)) slot++;
        if (slot >= NLIVE) return g;
        lo = int'(a) - DEF_HEADER_BYTES;
        hi = int'(a) + live_len[slot];
        merged = 1'b0;
        changed = 1'b1;
        for (int i = 0; i < NFREE; i++) gone[i] = 1'b0;
        while (changed)
        begin
            changed = 1'b0;
            for (int i = 0; i < NFREE; i++)
            begin
                s = ext_start[i];
                e = s + ext_len[i];
                if (!ext_vld[i] || gone[i]) continue;
                if (e == lo || s == hi)
                begin
                    if (s < lo) lo = s;
                    if (e > hi) hi = e;
                    gone[i] = 1'b1;
                    merged = 1'b1;
                    changed = 1'b1;
                end
            end
        end
        used = 0;
        for (int i = 0; i < NFREE; i++) if (ext_vld[i]) used++;
        if (!merged && used >= NFREE)
        begin
            g.st = ST_FULL;
            return g;
        end
        ns[0] = 20'(lo);
        nl[0] = 21'(hi - lo);
        n = 1;
        for (int i = 0; i < NFREE; i++)
        begin
            if (ext_vld[i] && !gone[i] && n < NFREE)
            begin
                ns[n] = ext_start[i];
                nl[n] = ext_len[i];
                n++;
            end
        end
        for (int i = 0; i < NFREE; i++)
        begin
            ext_vld[i] = (i < n);
            ext_start[i] = (i < n) ? ns[i] : '0;
            ext_len[i] = (i < n) ? nl[i] : '0;
        end
        live_vld[slot] = 1'b0;
        g.st = ST_OK;
        return g;
    endfunction

    assign pending = grants_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        grant_t g;
        int errs;
        errs = 0;
        if (!rst_n)
        begin
            pages_q = 9'd1;
            clear_tables();
            grants_due.delete();
            fail_count <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (done)
            begin
                results_seen <= results_seen + 1;
                if (grants_due.size() == 0)
                begin
                    $error("result with no request outstanding: addr %0h status %0d",
                           granted_address, status);
                    errs++;
                end
                else
                begin
                    g = grants_due.pop_front();
                    if (granted_address !== g.addr)
                    begin
                        $error("granted_address expected %0h actual %0h",
                               g.addr, granted_address);
                        errs++;
                    end
                    if (status !== g.st)
                    begin
                        $error("status expected %0d actual %0d", g.st, status);
                        errs++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                pages_q = region_pages;
                clear_tables();
            end
            if (start && !busy)
            begin
                if (mode == MODE_ALLOC)
                    g = allocate(request_bytes, fit_policy);
                else
                    g = release_block(release_address);
                grants_due.push_back(g);
            end
            fail_count <= fail_count + errs;
        end
    end

endmodule

// ===== dv/free_list_allocator_top_tb.sv =====
// Testbench top for the free list allocator: clock, reset, request stimulus
// and region writes over several region sizes; verdict from the checker.
// Depends on fla_pkg, free_list_allocator_top, free_list_allocator_checker.
`timescale 1ns / 1ps
module free_list_allocator_top_tb;
    import fla_pkg::*;

    localparam int PHASE_ITEMS = 250;
    localparam int DRAIN_CYCLES = 1200;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        mode = MODE_ALLOC;
    logic [20:0] request_bytes = '0;
    logic [1:0]  fit_policy = FIT_BEST;
    logic [19:0] release_address = '0;
    logic        cfg_valid = 1'b0;
    logic [8:0]  region_pages = 9'd1;
    logic        busy, done, cfg_ready;
    logic [19:0] granted_address;
    logic [1:0]  status;
    int          fail_count, pending, results_seen;
    int          requests_sent = 0;
    logic [19:0] live_blocks [$];
    int unsigned region_now = DEF_PAGE_BYTES;

    always #10 clk = ~clk;

    free_list_allocator_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .request_bytes(request_bytes), .fit_policy(fit_policy),
        .release_address(release_address), .done(done),
        .granted_address(granted_address), .status(status),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .region_pages(region_pages)
    );

    free_list_allocator_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .request_bytes(request_bytes), .fit_policy(fit_policy),
        .release_address(release_address), .done(done),
        .granted_address(granted_address), .status(status),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .region_pages(region_pages),
        .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
    );

    always @(posedge clk)
        if (done && status == ST_OK && granted_address != 0)
            live_blocks.push_back(granted_address);

    task automatic send(logic m, logic [20:0] req, logic [1:0] pol, logic [19:0] a);
        start <= 1'b1;
        mode <= m;
        request_bytes <= req;
        fit_policy <= pol;
        release_address <= a;
        do @(posedge clk); while (busy);
        requests_sent++;
    endtask

    task automatic settle();
        start <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_region(logic [8:0] p);
        int unsigned n;
        settle();
        cfg_valid <= 1'b1;
        region_pages <= p;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        region_pages <= 9'($urandom);
        live_blocks.delete();
        n = (p == 0) ? 1 : (p > MAX_PAGES) ? MAX_PAGES : p;
        region_now = n * DEF_PAGE_BYTES;
    endtask

    function automatic logic [19:0] take_live();
        int k;
        logic [19:0] a;
        if (live_blocks.size() == 0) return 20'($urandom);
        k = $urandom_range(0, live_blocks.size() - 1);
        a = live_blocks[k];
        live_blocks.delete(k);
        return a;
    endfunction

    task automatic directed();
        logic [19:0] a;
        send(MODE_ALLOC, 21'd0, FIT_BEST, 20'hFFFFF);
        send(MODE_ALLOC, 21'd1048576, FIT_WORST, 20'd0);
        send(MODE_ALLOC, 21'h1FFFFF, FIT_FIRST, 20'd0);
        send(MODE_ALLOC, 21'd100, FIT_WORST, 20'h12345);
        send(MODE_ALLOC, 21'd8, FIT_FIRST, 20'd0);
        send(MODE_ALLOC, 21'd8, 2'd3, 20'd0);
        send(MODE_ALLOC, 21'd4088, FIT_BEST, 20'd0);
        settle();
        a = take_live();
        send(MODE_FREE, 21'h1FFFFF, 2'd3, a);
        send(MODE_FREE, 21'd0, FIT_BEST, a);
        send(MODE_FREE, 21'd0, FIT_BEST, 20'hFFFFF);
        send(MODE_FREE, 21'd0, FIT_BEST, 20'd0);
        for (int i = 0; i < 17; i++)
            send(MODE_ALLOC, 21'($urandom_range(0, 40)), 2'($urandom_range(0, 2)), 20'd0);
        settle();
    endtask

    task automatic random_phase(int count);
        int gap_left, burst_left;
        logic [20:0] req;
        burst_left = $urandom_range(1, 20);
        for (int i = 0; i < count; i++)
        begin
            if (burst_left == 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge clk);
                burst_left = $urandom_range(1, 20);
            end
            burst_left--;
            gap_left = $urandom_range(0, 99);
            if (gap_left < 40 && live_blocks.size() != 0)
                send(MODE_FREE, 21'($urandom), 2'($urandom), take_live());
            else if (gap_left < 46)
                send(MODE_FREE, 21'($urandom), 2'($urandom), 20'($urandom));
            else
            begin
                case ($urandom_range(0, 19))
                    0:       req = 21'($urandom_range(0, 1048576));
                    1, 2:    req = 21'($urandom_range(0, region_now));
                    3, 4, 5: req = 21'($urandom_range(0, 2048));
                    default: req = 21'($urandom_range(0, 256));
                endcase
                send(MODE_ALLOC, req,
                     ($urandom_range(0, 30) == 0) ? 2'd3 : 2'($urandom_range(0, 2)),
                     20'($urandom));
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_region(9'd1);
        directed();
        random_phase(PHASE_ITEMS);
        set_region(9'd0);
        random_phase(PHASE_ITEMS);
        set_region(9'd2);
        random_phase(PHASE_ITEMS);
        set_region(9'd256);
        random_phase(PHASE_ITEMS);
        set_region(9'd511);
        random_phase(PHASE_ITEMS / 2);
        set_region(9'd300);
        random_phase(PHASE_ITEMS / 2);
        set_region(9'($urandom_range(3, 16)));
        random_phase(PHASE_ITEMS);
        set_region(9'd1);
        random_phase(PHASE_ITEMS);
        settle();
        $display("covered %0d requests over 8 region settings, %0d results checked",
                 requests_sent, results_seen);
        if (fail_count == 0)
            $display("PASS free_list_allocator_top");
        else
            $display("FAIL free_list_allocator_top");
        $finish;
    end

    initial
    begin
        #200_000_000;
        $display("FAIL free_list_allocator_top");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/fla_pkg.sv
sv/fla_ram.sv
sv/fla_front.sv
sv/fla_queue.sv
sv/fla_back.sv
sv/free_list_allocator_top.sv
sv/fla_checker.sv
dv/free_list_allocator_checker.sv
dv/free_list_allocator_top_tb.sv
